### src/bruck_allgatherv_schedule_core_assert.svh
// Assertion macros for the schedule core checker.
`ifndef BRUCK_ALLGATHERV_SCHEDULE_CORE_ASSERT_SVH
`define BRUCK_ALLGATHERV_SCHEDULE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BAGV_AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BAGV_AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bagv_pkg.sv
// Shared constants, codes and types of the Bruck all-gather schedule core.
`timescale 1ns / 1ps

package bagv_pkg;

    localparam int MAX_RANKS   = 64;
    localparam int COUNT_BITS  = 16;
    localparam int ADDR_W      = $clog2(MAX_RANKS);

    localparam int RANK_W      = 6;
    localparam int NR_W        = 7;
    localparam int CNT_FIELD_W = 16;
    localparam int ROUND_W     = 3;
    localparam int ELEM_W      = 22;
    localparam int TOT_W       = 23;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 7;
    localparam int MSTEP_W     = $clog2(RANK_W);
    localparam int MOD_W       = NR_W + RANK_W - 1;

    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_GEN  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_RANKS = 1'b0,
        REG_MY_RANK   = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_WALK,
        ST_XTRA
    } t_state;

    typedef struct packed {
        logic              start;
        logic [NR_W-1:0]   n;
        logic [RANK_W-1:0] me;
    } t_gen_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

endpackage

### src/bagv_if.sv
// Valid/ready channel interfaces for command words and schedule words.
`timescale 1ns / 1ps

interface bagv_in_if;
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic [bagv_pkg::RANK_W-1:0]    rank_index;
    logic [bagv_pkg::CNT_FIELD_W-1:0] count;

    modport source (output valid, cmd, rank_index, count, input ready);
    modport sink   (input valid, cmd, rank_index, count, output ready);
endinterface

interface bagv_out_if;
    logic                          valid;
    logic                          ready;
    logic [bagv_pkg::ROUND_W-1:0]  round;
    logic [bagv_pkg::RANK_W-1:0]   dst_rank;
    logic [bagv_pkg::RANK_W-1:0]   src_rank;
    logic [bagv_pkg::ELEM_W-1:0]   send_elems;
    logic [bagv_pkg::ELEM_W-1:0]   recv_offset;
    logic [bagv_pkg::ELEM_W-1:0]   recv_elems;
    logic                          last;

    modport source (output valid, round, dst_rank, src_rank, send_elems,
                    recv_offset, recv_elems, last, input ready);
    modport sink   (input valid, round, dst_rank, src_rank, send_elems,
                    recv_offset, recv_elems, last, output ready);
endinterface

### src/bagv_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module bagv_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bagv_sched.sv
// Schedule sequencer: rank reduction, count table walk and result register.
`timescale 1ns / 1ps

module bagv_sched (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bagv_pkg::t_gen_req              i_gen,
    output logic                            o_idle,
    output bagv_pkg::t_rd_req               o_rd,
    input  logic [bagv_pkg::COUNT_BITS-1:0] i_rd_data,
    bagv_out_if.source                      o_out
);

    localparam int NR_W    = bagv_pkg::NR_W;
    localparam int RANK_W  = bagv_pkg::RANK_W;
    localparam int ADDR_W  = bagv_pkg::ADDR_W;
    localparam int ROUND_W = bagv_pkg::ROUND_W;
    localparam int ELEM_W  = bagv_pkg::ELEM_W;
    localparam int TOT_W   = bagv_pkg::TOT_W;
    localparam int MSTEP_W = bagv_pkg::MSTEP_W;
    localparam int MOD_W   = bagv_pkg::MOD_W;

    bagv_pkg::t_state r_state, n_state;

    logic [NR_W-1:0]    r_n;
    logic [RANK_W-1:0]  r_me, n_me;
    logic [MSTEP_W-1:0] r_mstep;
    logic [ADDR_W-1:0]  r_addr;
    logic [NR_W-1:0]    r_issued;
    logic [NR_W-1:0]    r_plen;
    logic               r_dvalid;
    logic [TOT_W-1:0]   r_acc;
    logic [TOT_W-1:0]   r_held;
    logic [TOT_W-1:0]   r_se;
    logic [TOT_W-1:0]   r_total;
    logic [ROUND_W-1:0] r_round;

    logic               r_ovalid;
    logic [ROUND_W-1:0] r_oround, n_oround;
    logic [RANK_W-1:0]  r_osp, n_osp;
    logic [RANK_W-1:0]  r_orp, n_orp;
    logic [ELEM_W-1:0]  r_osend, n_osend;
    logic [ELEM_W-1:0]  r_ooff, n_ooff;
    logic [ELEM_W-1:0]  r_orecv, n_orecv;
    logic               r_olast, n_olast;

    logic [ROUND_W-1:0] rounds;
    logic [NR_W-1:0]    full;
    logic               extra;
    logic [NR_W-1:0]    gap;
    logic [NR_W-1:0]    me_w;
    logic [NR_W-1:0]    fwd;
    logic [NR_W-1:0]    bwd;
    logic [MOD_W-1:0]   mod_div;
    logic               can_emit;
    logic               advance;
    logic               issue;
    logic               step;
    logic               at_end;
    logic               emit_norm;
    logic               emit;
    logic [TOT_W-1:0]   acc_new;

    // Round count is the position of the top set bit of n.
    always_comb begin
        rounds = '0;
        for (int b = 1; b < NR_W; b++) begin
            if (r_n[b]) begin
                rounds = ROUND_W'(b);
            end
        end
    end

    assign full  = NR_W'(1) << rounds;
    assign extra = (r_n & (r_n - NR_W'(1))) != '0;

    // Partners for the current gap; gap never exceeds n.
    assign gap  = NR_W'(1) << r_round;
    assign me_w = NR_W'(r_me);
    assign fwd  = (me_w + gap >= r_n) ? me_w + gap - r_n : me_w + gap;
    assign bwd  = (me_w >= gap) ? me_w - gap : me_w + r_n - gap;

    // One restoring step of my_rank mod n per cycle.
    assign mod_div = MOD_W'(r_n) << r_mstep;
    always_comb begin
        if (MOD_W'(r_me) >= mod_div) begin
            n_me = r_me - RANK_W'(mod_div);
        end else begin
            n_me = r_me;
        end
    end

    assign can_emit  = !r_ovalid || o_out.ready;
    assign advance   = !r_dvalid || can_emit;
    assign issue     = (r_state == bagv_pkg::ST_WALK) && advance && (r_issued != r_n);
    assign step      = (r_state == bagv_pkg::ST_WALK) && r_dvalid && can_emit;
    assign acc_new   = r_acc + TOT_W'(i_rd_data);
    assign at_end    = step && (r_plen == r_n);
    assign emit_norm = step && (r_round < rounds) && (r_plen == (gap << 1));

    always_comb begin
        n_state  = r_state;
        emit     = 1'b0;
        n_oround = r_round;
        n_osp    = RANK_W'(bwd);
        n_orp    = RANK_W'(fwd);
        n_osend  = ELEM_W'(r_held);
        n_ooff   = ELEM_W'(r_held);
        n_orecv  = ELEM_W'(acc_new - r_held);
        n_olast  = !extra && (ROUND_W'(r_round + ROUND_W'(1)) == rounds);
        case (r_state)
            bagv_pkg::ST_IDLE: begin
                if (i_gen.start) begin
                    n_state = bagv_pkg::ST_MOD;
                end
            end
            bagv_pkg::ST_MOD: begin
                if (r_mstep == '0) begin
                    n_state = bagv_pkg::ST_WALK;
                end
            end
            bagv_pkg::ST_WALK: begin
                emit = emit_norm;
                if (at_end) begin
                    n_state = extra ? bagv_pkg::ST_XTRA : bagv_pkg::ST_IDLE;
                end
            end
            bagv_pkg::ST_XTRA: begin
                // Remainder round: send what the partner lacks, take the rest.
                n_osend = ELEM_W'(r_se);
                n_orecv = ELEM_W'(r_total - r_held);
                n_olast = 1'b1;
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = bagv_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bagv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bagv_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= 1'b0;
            r_total  <= '0;
        end else begin
            case (r_state)
                bagv_pkg::ST_IDLE: begin
                    if (i_gen.start) begin
                        r_n      <= i_gen.n;
                        r_me     <= i_gen.me;
                        r_mstep  <= MSTEP_W'(RANK_W - 1);
                        r_issued <= '0;
                        r_dvalid <= 1'b0;
                        r_acc    <= '0;
                        r_round  <= '0;
                    end
                end
                bagv_pkg::ST_MOD: begin
                    r_me    <= n_me;
                    r_mstep <= r_mstep - MSTEP_W'(1);
                    r_addr  <= ADDR_W'(n_me);
                end
                bagv_pkg::ST_WALK: begin
                    if (issue) begin
                        r_addr   <= (NR_W'(r_addr) == r_n - NR_W'(1)) ? '0
                                                                       : r_addr + ADDR_W'(1);
                        r_issued <= r_issued + NR_W'(1);
                        r_plen   <= r_issued + NR_W'(1);
                    end
                    if (advance) begin
                        r_dvalid <= issue;
                    end
                    if (step) begin
                        r_acc <= acc_new;
                        if (r_plen == NR_W'(1)) begin
                            r_held <= acc_new;
                        end
                        if (r_plen == r_n - full) begin
                            r_se <= acc_new;
                        end
                    end
                    if (emit_norm) begin
                        r_held  <= acc_new;
                        r_round <= r_round + ROUND_W'(1);
                    end
                    if (at_end) begin
                        r_total <= acc_new;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: load on emit, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_oround <= n_oround;
            r_osp    <= n_osp;
            r_orp    <= n_orp;
            r_osend  <= n_osend;
            r_ooff   <= n_ooff;
            r_orecv  <= n_orecv;
            r_olast  <= n_olast;
        end
    end

    assign o_idle  = (r_state == bagv_pkg::ST_IDLE);
    assign o_rd.en   = issue;
    assign o_rd.addr = r_addr;

    assign o_out.valid       = r_ovalid;
    assign o_out.round       = r_oround;
    assign o_out.dst_rank    = r_osp;
    assign o_out.src_rank    = r_orp;
    assign o_out.send_elems  = r_osend;
    assign o_out.recv_offset = r_ooff;
    assign o_out.recv_elems  = r_orecv;
    assign o_out.last        = r_olast;

endmodule

### src/bruck_allgatherv_schedule_core.sv
// Top level of the Bruck all-gather schedule core.
//
// Command words arrive on i_in. A load word (cmd 0) writes one rank's element
// count into the count table; it gives no result. A generate word (cmd 1)
// produces one schedule word per exchange round on o_out, the final one
// flagged by last; a single rank gives none. A generate holds i_in closed
// while ST_MOD reduces my_rank modulo n and the walk then issues the first
// count table read and takes one entry per cycle while o_out is not stalled,
// through the table RAM's single read port, accumulating as it goes and
// issuing each round's word when its window closes; the remainder round, if
// any, follows the walk. i_in stays closed until the final word has been
// placed in the output register. A stall on o_out holds the output register
// and pauses the walk. Configuration goes through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce. Reset sets one rank, rank 0, and empties the
// output; the count table is not cleared and must be loaded before a generate.
`timescale 1ns / 1ps

module bruck_allgatherv_schedule_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bagv_in_if.sink                        i_in,
    bagv_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [bagv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bagv_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int NR_W   = bagv_pkg::NR_W;
    localparam int RANK_W = bagv_pkg::RANK_W;
    localparam int ADDR_W = bagv_pkg::ADDR_W;

    logic [NR_W-1:0]   r_num_ranks;
    logic [RANK_W-1:0] r_my_rank;
    logic [NR_W-1:0]   n_clamped;
    logic              idle;
    logic              in_acc;
    logic              tbl_we;
    logic [bagv_pkg::COUNT_BITS-1:0] rd_data;

    bagv_pkg::t_gen_req gen;
    bagv_pkg::t_rd_req  rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ranks <= NR_W'(1);
            r_my_rank   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bagv_pkg::REG_NUM_RANKS: r_num_ranks <= NR_W'(i_cfg_data);
                bagv_pkg::REG_MY_RANK:   r_my_rank   <= i_cfg_data[RANK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Zero ranks behaves as one; saturate at the table depth.
    always_comb begin
        if (r_num_ranks == '0) begin
            n_clamped = NR_W'(1);
        end else if (int'(r_num_ranks) > bagv_pkg::MAX_RANKS) begin
            n_clamped = NR_W'(bagv_pkg::MAX_RANKS);
        end else begin
            n_clamped = r_num_ranks;
        end
    end

    assign i_in.ready = idle;
    assign in_acc     = i_in.valid && idle;
    assign tbl_we     = in_acc && (i_in.cmd == bagv_pkg::CMD_LOAD)
                        && (int'(i_in.rank_index) < bagv_pkg::MAX_RANKS);

    assign gen.start = in_acc && (i_in.cmd == bagv_pkg::CMD_GEN);
    assign gen.n     = n_clamped;
    assign gen.me    = r_my_rank;

    // Loads only land while idle, so the walk never overlaps a table write.
    bagv_ram #(
        .DEPTH (bagv_pkg::MAX_RANKS),
        .WIDTH (bagv_pkg::COUNT_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (ADDR_W'(i_in.rank_index)),
        .i_wdata (i_in.count[bagv_pkg::COUNT_BITS-1:0]),
        .i_re    (rd.en),
        .i_raddr (rd.addr),
        .o_rdata (rd_data)
    );

    bagv_sched u_sched (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gen     (gen),
        .o_idle    (idle),
        .o_rd      (rd),
        .i_rd_data (rd_data),
        .o_out     (o_out)
    );

endmodule

### src/bagv_checker.sv
// Port-level checker for the schedule core, bound to the top level.
`timescale 1ns / 1ps
`include "bruck_allgatherv_schedule_core_assert.svh"

module bagv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_in_cmd,
    input logic                          o_out_valid,
    input logic                          o_out_ready,
    input logic [bagv_pkg::ROUND_W-1:0]  o_round,
    input logic [bagv_pkg::ELEM_W-1:0]   o_send_elems,
    input logic [bagv_pkg::ELEM_W-1:0]   o_recv_offset,
    input logic [bagv_pkg::ELEM_W-1:0]   o_recv_elems,
    input logic                          o_last
);

    // A stalled result word must not change.
    `BAGV_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !o_out_ready, o_out_valid && $stable(o_round) && $stable(o_send_elems) && $stable(o_recv_elems) && $stable(o_last), "stalled result word changed")

    // A generate closes the command channel in the next cycle.
    `BAGV_AST_NEXT(a_gen_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_cmd == bagv_pkg::CMD_GEN), !i_in_ready, "command channel open right after a generate")

    // Until the final word is out, no new command is taken.
    `BAGV_AST_SAME(a_open_sched, i_clk, i_rst_n, o_out_valid && !o_last, !i_in_ready, "command channel open mid-schedule")

    // Doubling rounds send exactly what they already hold.
    `BAGV_AST_SAME(a_send_held, i_clk, i_rst_n, o_out_valid && !o_last, o_send_elems == o_recv_offset, "send count differs from held count")

endmodule

bind bruck_allgatherv_schedule_core bagv_checker u_bagv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_cmd      (i_in.cmd),
    .o_out_valid   (o_out.valid),
    .o_out_ready   (o_out.ready),
    .o_round       (o_out.round),
    .o_send_elems  (o_out.send_elems),
    .o_recv_offset (o_out.recv_offset),
    .o_recv_elems  (o_out.recv_elems),
    .o_last        (o_out.last)
);

### tb/bruck_allgatherv_schedule_core_test.sv
// Self-checking testbench for the Bruck all-gather schedule core.
`timescale 1ns / 1ps

module bruck_allgatherv_schedule_core_test;

    localparam int MAX_RANKS   = bagv_pkg::MAX_RANKS;
    localparam int RANK_W      = bagv_pkg::RANK_W;
    localparam int NR_W        = bagv_pkg::NR_W;
    localparam int CNT_FIELD_W = bagv_pkg::CNT_FIELD_W;
    localparam int ROUND_W     = bagv_pkg::ROUND_W;
    localparam int ELEM_W      = bagv_pkg::ELEM_W;
    localparam int CFG_IDX_W   = bagv_pkg::CFG_IDX_W;
    localparam int CFG_W       = bagv_pkg::CFG_W;

    localparam int RAND_WORDS = 270;
    localparam int SETTLE     = 100;
    localparam int LONG_HOLD  = 400;
    localparam int IDLE_LIMIT = 4000;

    typedef struct packed {
        bagv_pkg::t_cmd         cmd;
        logic [RANK_W-1:0]      idx;
        logic [CNT_FIELD_W-1:0] cnt;
    } t_cmd_word;

    typedef struct packed {
        logic [ROUND_W-1:0] round;
        logic [RANK_W-1:0]  dst_rank;
        logic [RANK_W-1:0]  src_rank;
        logic [ELEM_W-1:0]  send_elems;
        logic [ELEM_W-1:0]  recv_offset;
        logic [ELEM_W-1:0]  recv_elems;
        logic               last;
    } t_sched_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bagv_in_if  in_if();
    bagv_out_if out_if();

    bruck_allgatherv_schedule_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus side
    t_cmd_word   pending_cmds[$];
    bit          planned[MAX_RANKS];

    // Prediction side
    t_sched_word sched_q[$];
    logic [CNT_FIELD_W-1:0] count_tab[MAX_RANKS];
    logic [NR_W-1:0]   cfg_nr = 7'd1;
    logic [RANK_W-1:0] cfg_me = 6'd0;

    int errors    = 0;
    int load_cnt  = 0;
    int gen_cnt   = 0;
    int word_cnt  = 0;
    int cfg_cnt   = 0;

    int  burst_left, gap_left;
    int  hold_left;
    bit  hold_go = 1'b0;
    bit  hold_done;
    int  rx_mode;
    logic [7:0] rx_tick;
    int  idle_cycles;

    task automatic flag_mismatch(string msg);
        errors++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic int unsigned ranks_in_use(logic [NR_W-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_RANKS)
            return MAX_RANKS;
        return raw;
    endfunction

    function automatic int unsigned window_sum(int unsigned start, int unsigned len,
                                               int unsigned n);
        int unsigned acc;
        acc = 0;
        for (int unsigned p = 0; p < len; p++)
            acc += count_tab[(start + p) % n];
        return acc;
    endfunction

    // Queue one word per exchange round for the current configuration.
    function automatic void plan_schedule();
        int unsigned n, me, total, rounds, full, gap, held, got, sp, rp, partner_has;
        bit extra;
        t_sched_word w;
        n = ranks_in_use(cfg_nr);
        me = cfg_me % n;
        total = 0;
        for (int unsigned k = 0; k < n; k++)
            total += count_tab[k];
        rounds = 0;
        full = 1;
        while (full * 2 <= n) begin
            full *= 2;
            rounds++;
        end
        extra = (full != n);
        gap = 1;
        held = count_tab[me];
        for (int unsigned r = 0; r < rounds; r++) begin
            rp = (me + gap) % n;
            got = window_sum(rp, gap, n);
            w.round       = ROUND_W'(r);
            w.dst_rank    = RANK_W'((me + n - gap) % n);
            w.src_rank    = RANK_W'(rp);
            w.send_elems  = ELEM_W'(held);
            w.recv_offset = ELEM_W'(held);
            w.recv_elems  = ELEM_W'(got);
            w.last        = !extra && (r + 1 == rounds);
            sched_q.push_back(w);
            held += got;
            gap *= 2;
        end
        // Remainder round: exchange whatever neither side holds yet.
        if (extra) begin
            sp = (me + n - gap) % n;
            partner_has = window_sum(sp, gap, n);
            w.round       = ROUND_W'(rounds);
            w.dst_rank    = RANK_W'(sp);
            w.src_rank    = RANK_W'((me + gap) % n);
            w.send_elems  = ELEM_W'((total >= partner_has) ? total - partner_has : 0);
            w.recv_offset = ELEM_W'(held);
            w.recv_elems  = ELEM_W'((total >= held) ? total - held : 0);
            w.last        = 1'b1;
            sched_q.push_back(w);
        end
    endfunction

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            flag_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    // Command driver: bursts of words separated by random gaps
    always @(posedge i_clk) begin : drive_cmds
        t_cmd_word w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (gap_left != 0 || pending_cmds.size() == 0) begin
                in_if.valid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end else begin
                w = pending_cmds.pop_front();
                in_if.valid      <= 1'b1;
                in_if.cmd        <= w.cmd;
                in_if.rank_index <= w.idx;
                in_if.count      <= w.cnt;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Schedule receiver: shifting stall patterns plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
            rx_mode      <= 0;
            rx_tick      <= '0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_left    <= LONG_HOLD;
            hold_done    <= 1'b1;
            out_if.ready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 8'd1;
            if (rx_tick[5:0] == 0)
                rx_mode <= $urandom_range(0, 2);
            case (rx_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= ($urandom_range(0, 3) != 0);
                default: out_if.ready <= (rx_tick[2:0] == 0);
            endcase
        end
    end

    // Monitor: track loads, predict on generate, check every schedule word
    always @(posedge i_clk) begin : watch_ports
        t_sched_word want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                if (in_if.cmd == bagv_pkg::CMD_LOAD) begin
                    count_tab[in_if.rank_index] = in_if.count;
                    load_cnt++;
                end else begin
                    plan_schedule();
                    gen_cnt++;
                end
            end
            if (out_if.valid && out_if.ready) begin
                word_cnt++;
                if (sched_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word, round %0d", out_if.round));
                end else begin
                    want = sched_q.pop_front();
                    check_field("round",       out_if.round,       want.round);
                    check_field("dst_rank",    out_if.dst_rank,    want.dst_rank);
                    check_field("src_rank",    out_if.src_rank,    want.src_rank);
                    check_field("send_elems",  out_if.send_elems,  want.send_elems);
                    check_field("recv_offset", out_if.recv_offset, want.recv_offset);
                    check_field("recv_elems",  out_if.recv_elems,  want.recv_elems);
                    check_field("last",        out_if.last,        want.last);
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("bruck_allgatherv_schedule_core_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [CNT_FIELD_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CNT_FIELD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void push_load(int unsigned idx, logic [CNT_FIELD_W-1:0] cnt);
        t_cmd_word w;
        w.cmd = bagv_pkg::CMD_LOAD;
        w.idx = RANK_W'(idx);
        w.cnt = cnt;
        planned[idx] = 1'b1;
        pending_cmds.push_back(w);
    endfunction

    function automatic void push_gen();
        t_cmd_word w;
        w.cmd = bagv_pkg::CMD_GEN;
        w.idx = RANK_W'($urandom_range(0, 63));
        w.cnt = CNT_FIELD_W'($urandom_range(0, 65535));
        pending_cmds.push_back(w);
    endfunction

    // Load every entry a generate will read that has not been loaded yet.
    function automatic int fill_table(int unsigned n);
        int pushed;
        pushed = 0;
        for (int unsigned k = 0; k < n; k++)
            if (!planned[k]) begin
                push_load(k, pick_count());
                pushed++;
            end
        return pushed;
    endfunction

    task automatic set_config(logic [NR_W-1:0] nr, logic [RANK_W-1:0] me);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= bagv_pkg::REG_NUM_RANKS;
        i_cfg_data <= CFG_W'(nr);
        @(posedge i_clk);
        i_cfg_idx  <= bagv_pkg::REG_MY_RANK;
        i_cfg_data <= CFG_W'(me);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_nr = nr;
        cfg_me = me;
        cfg_cnt++;
    endtask

    // Hold until every queued word is taken and every schedule word is back.
    task automatic drain();
        while (pending_cmds.size() != 0 || in_if.valid || sched_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int          rand_words;
        int          phase;
        int          len;
        int unsigned gen_odds;
        logic [NR_W-1:0] nr;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = bagv_pkg::REG_NUM_RANKS;
        i_cfg_data       = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single rank after reset, zero rank count, wrap, remainder
        // round, power of two, index and count extremes.
        push_load(0, 16'hFFFF);
        push_gen();
        drain();
        set_config(7'd0, 6'd63);
        push_gen();
        drain();
        set_config(7'd2, 6'd1);
        push_load(1, 16'h0000);
        push_load(63, 16'hFFFF);
        push_load(1, 16'h0001);
        push_gen();
        drain();
        set_config(7'd3, 6'd5);
        push_load(2, 16'hFFFF);
        push_gen();
        drain();
        set_config(7'd4, 6'd3);
        push_load(3, 16'h0000);
        push_gen();
        drain();
        set_config(7'd7, 6'd0);
        push_load(4, 16'hFFFF);
        push_load(5, 16'h0000);
        push_load(6, 16'h8000);
        push_gen();
        push_gen();
        drain();

        // Random phases: loads then generates, with the extremes of the
        // rank count first and the long receiver hold-off in the third.
        rand_words = 0;
        phase = 0;
        while (rand_words < RAND_WORDS) begin
            case (phase)
                0:       nr = 7'd64;
                1:       nr = 7'd127;
                2:       nr = 7'd65;
                3:       nr = 7'd1;
                4:       nr = 7'd0;
                default: nr = ($urandom_range(0, 3) == 0) ? NR_W'($urandom_range(0, 127))
                                                          : NR_W'($urandom_range(2, 16));
            endcase
            set_config(nr, RANK_W'($urandom_range(0, 63)));
            if (phase == 2)
                hold_go <= 1'b1;
            gen_odds = (phase == 2) ? 2 : 4;
            rand_words += fill_table(ranks_in_use(nr));
            len = $urandom_range(8, 30);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(1, gen_odds) == 1)
                    push_gen();
                else
                    push_load($urandom_range(0, 63), pick_count());
                rand_words++;
            end
            drain();
            phase++;
        end

        $display("Ran %0d rank-count loads and %0d generates over %0d configurations;",
                 load_cnt, gen_cnt, cfg_cnt);
        $display("checked %0d schedule words, including one long output hold-off.",
                 word_cnt);
        if (errors == 0)
            $display("bruck_allgatherv_schedule_core_test passed");
        else
            $display("bruck_allgatherv_schedule_core_test failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/bagv_pkg.sv
src/bagv_if.sv
src/bagv_ram.sv
src/bagv_sched.sv
src/bruck_allgatherv_schedule_core.sv
src/bagv_checker.sv
tb/bruck_allgatherv_schedule_core_test.sv
